### rtl/core/lru_ev_pkg.sv
// lru evictor package: sizes, command and result codes, cell status struct
// used by all modules of the lru evictor block
package lru_ev_pkg;
  localparam int unsigned Entries   = 16;
  localparam int unsigned SlotBits  = 4;
  localparam int unsigned AgeBits   = 4;
  localparam int unsigned TotBits   = 5;
  localparam int unsigned KeyBits   = 32;
  localparam int unsigned CountBits = 16;

  localparam logic [1:0] CmdLookup  = 2'd0;
  localparam logic [1:0] CmdRelease = 2'd1;
  localparam logic [1:0] CmdDrain   = 2'd2;
  localparam logic [1:0] CmdUnused  = 2'd3;

  localparam logic [2:0] KindHit      = 3'd0;
  localparam logic [2:0] KindInserted = 3'd1;
  localparam logic [2:0] KindRefused  = 3'd2;
  localparam logic [2:0] KindFull     = 3'd3;
  localparam logic [2:0] KindReleased = 3'd4;
  localparam logic [2:0] KindDrained  = 3'd5;
  localparam logic [2:0] KindEvicted  = 3'd6;
  localparam logic [2:0] KindBadRel   = 3'd7;

  // per-cell operation issued by the sequencer
  typedef enum logic [2:0] {
    OpNone, OpHit, OpInsert, OpRelease, OpEvict, OpCompact
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [SlotBits-1:0]  slot;      // slot addressed by hit/insert/release/evict
    logic [AgeBits-1:0]   age;       // age of the hit entry, or evicted age
    logic [KeyBits-1:0]   key;
  } cell_ctl_t;

  typedef struct packed {
    logic                 valid;
    logic [KeyBits-1:0]   key;
    logic [CountBits-1:0] uses;
    logic [AgeBits-1:0]   age;
  } cell_st_t;
endpackage

### rtl/core/lru_evictor_with_pin_counts.sv
// lru evictor with pin counts: lookup/release/drain over a row of 16 entry cells
// the input word is captured on acceptance; its result is registered in StCmd;
// a command is taken only in StIdle; in_stall_o is high in every other state;
// release and drain go on to the eviction scan, which walks one age per cycle
// while the output is not stalled, oldest first, with a StCompact step after
// each eviction; reset empties the table, clears draining, sets size_limit to 16
module lru_evictor_with_pin_counts (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] key_i,
  input  logic        create_ok_i,
  input  logic [3:0]  slot_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_res_o,
  output logic [31:0] key_res_o,
  output logic [15:0] use_count_o,
  output logic        last_o
);
  import lru_ev_pkg::*;

  typedef enum logic [1:0] {
    StIdle, StCmd, StScan, StCompact
  } state_e;

  state_e               state_q;
  logic [4:0]           limit_q;
  logic                 drain_q;
  logic [TotBits-1:0]   total_q;
  logic [TotBits-1:0]   age_q;      // next age to examine, plus one
  logic [1:0]           cmd_q;
  logic [KeyBits-1:0]   key_q;
  logic                 create_q;
  logic [SlotBits-1:0]  slot_q;
  logic [AgeBits-1:0]   gap_q;      // age of evicted entry for compact
  cell_ctl_t            ctl;
  cell_st_t             st [Entries];

  // output word register
  logic                 ov_q;
  logic [2:0]           kind_q;
  logic [SlotBits-1:0]  oslot_q;
  logic [KeyBits-1:0]   okey_q;
  logic [CountBits-1:0] ouse_q;
  logic                 olast_q;

  // next output word
  logic                 ld;
  logic [2:0]           w_kind;
  logic [SlotBits-1:0]  w_slot;
  logic [KeyBits-1:0]   w_key;
  logic [CountBits-1:0] w_use;
  logic                 w_last;

  // row of entry cells
  for (genvar g = 0; g < Entries; g++) begin : g_cell
    lru_ev_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .idx_i (SlotBits'(g)),
      .ctl_i (ctl),
      .st_o  (st[g])
    );
  end

  // match searches across the row
  logic                hit_f, free_f, age_f;
  logic [SlotBits-1:0] hit_s, free_s, age_s;
  always_comb begin
    hit_f = 1'b0; free_f = 1'b0; age_f = 1'b0;
    hit_s = '0; free_s = '0; age_s = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (st[i].valid && st[i].key == key_q) begin
        hit_f = 1'b1; hit_s = SlotBits'(i);
      end
      if (!st[i].valid) begin
        free_f = 1'b1; free_s = SlotBits'(i);
      end
      if (st[i].valid && {1'b0, st[i].age} == age_q - 1'b1) begin
        age_f = 1'b1; age_s = SlotBits'(i);
      end
    end
  end

  logic [4:0] lim;
  assign lim = drain_q ? 5'd0 : limit_q;

  // limit in force for the scan that follows the command word
  logic [4:0] lim_cmd;
  assign lim_cmd = (drain_q || cmd_q == CmdDrain) ? 5'd0 : limit_q;

  logic       more;     // another age at or above the limit is left to examine
  assign more = (age_q > lim);

  logic       st_out_free;
  assign st_out_free = !ov_q || !out_stall_i;

  // evictions that follow the command word, or the current eviction word
  logic evict_cmd, evict_after;
  always_comb begin
    evict_cmd   = 1'b0;
    evict_after = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      if (st[i].valid && {1'b0, st[i].age} >= lim_cmd
          && (st[i].uses == '0
              || (cmd_q == CmdRelease && slot_q == SlotBits'(i)
                  && st[i].uses == {{(CountBits-1){1'b0}}, 1'b1})))
        evict_cmd = 1'b1;
      if (st[i].valid && st[i].uses == '0 && {1'b0, st[i].age} >= lim
          && {1'b0, st[i].age} < age_q - 1'b1)
        evict_after = 1'b1;
    end
  end

  // cell control
  always_comb begin
    ctl = '{op: OpNone, slot: slot_q, age: '0, key: key_q};
    unique case (state_q)
      StCmd: begin
        if (st_out_free) begin
          if (cmd_q == CmdLookup && hit_f) begin
            ctl.op = OpHit; ctl.slot = hit_s; ctl.age = st[hit_s].age;
          end else if (cmd_q == CmdLookup && create_q && free_f) begin
            ctl.op = OpInsert; ctl.slot = free_s;
          end else if (cmd_q == CmdRelease) begin
            ctl.op = OpRelease;
          end
        end
      end
      StScan: begin
        if (st_out_free && more && age_f && st[age_s].uses == '0) begin
          ctl.op = OpEvict; ctl.slot = age_s;
        end
      end
      StCompact: begin
        ctl.op = OpCompact; ctl.age = gap_q;
      end
      default: ;
    endcase
  end

  // output word for the command or for an eviction
  always_comb begin
    ld     = 1'b0;
    w_kind = KindHit;
    w_slot = '0;
    w_key  = key_q;
    w_use  = '0;
    w_last = 1'b1;
    unique case (state_q)
      StCmd: begin
        ld = st_out_free;
        if (cmd_q == CmdLookup) begin
          if (hit_f) begin
            w_kind = KindHit;
            w_slot = hit_s;
            w_use  = (st[hit_s].uses == '1) ? st[hit_s].uses
                                             : st[hit_s].uses + 1'b1;
          end else if (!create_q) begin
            w_kind = KindRefused;
          end else if (!free_f) begin
            w_kind = KindFull;
          end else begin
            w_kind = KindInserted;
            w_slot = free_s;
            w_use  = {{(CountBits-1){1'b0}}, 1'b1};
          end
        end else if (cmd_q == CmdDrain) begin
          w_kind = KindDrained;
          w_key  = '0;
          w_last = !evict_cmd;
        end else begin
          w_slot = slot_q;
          w_key  = st[slot_q].valid ? st[slot_q].key : '0;
          w_use  = st[slot_q].valid ? st[slot_q].uses : '0;
          w_last = !evict_cmd;
          if (st[slot_q].valid && st[slot_q].uses != '0) begin
            w_kind = KindReleased;
            w_use  = st[slot_q].uses - 1'b1;
          end else begin
            w_kind = KindBadRel;
          end
        end
      end
      StScan: begin
        ld     = (ctl.op == OpEvict);
        w_kind = KindEvicted;
        w_slot = age_s;
        w_key  = st[age_s].key;
        w_last = !evict_after;
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  // sequencer and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      limit_q <= 5'd16;
      drain_q <= 1'b0;
      total_q <= '0;
      age_q   <= '0;
      gap_q   <= '0;
      ov_q    <= 1'b0;
      kind_q  <= KindHit;
      oslot_q <= '0;
      okey_q  <= '0;
      ouse_q  <= '0;
      olast_q <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      ov_q <= ld || (ov_q && out_stall_i);
      if (ld) begin
        kind_q  <= w_kind;
        oslot_q <= w_slot;
        okey_q  <= w_key;
        ouse_q  <= w_use;
        olast_q <= w_last;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && cmd_i != CmdUnused) state_q <= StCmd;
        end
        StCmd: begin
          if (st_out_free) begin
            age_q <= total_q;
            if (cmd_q == CmdLookup) begin
              if (!hit_f && create_q && free_f) total_q <= total_q + 1'b1;
              state_q <= StIdle;
            end else begin
              if (cmd_q == CmdDrain) drain_q <= 1'b1;
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          if (st_out_free) begin
            if (!more) begin
              state_q <= StIdle;
            end else begin
              age_q <= age_q - 1'b1;
              if (ctl.op == OpEvict) begin
                gap_q   <= st[age_s].age;
                total_q <= total_q - 1'b1;
                state_q <= StCompact;
              end
            end
          end
        end
        StCompact: begin
          state_q <= StScan;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // capture the input word
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      cmd_q    <= cmd_i;
      key_q    <= key_i;
      create_q <= create_ok_i;
      slot_q   <= slot_i;
    end
  end

  assign out_valid_o = ov_q;
  assign kind_o      = kind_q;
  assign slot_res_o  = oslot_q;
  assign key_res_o   = okey_q;
  assign use_count_o = ouse_q;
  assign last_o      = olast_q;
endmodule

### rtl/core/lru_ev_cell.sv
// lru evictor cell: one table entry with valid, key, use count and age
// depends on lru_ev_pkg
module lru_ev_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [lru_ev_pkg::SlotBits-1:0] idx_i,
  input  lru_ev_pkg::cell_ctl_t ctl_i,
  output lru_ev_pkg::cell_st_t  st_o
);
  import lru_ev_pkg::*;

  logic                 valid_q, valid_d;
  logic [KeyBits-1:0]   key_q, key_d;
  logic [CountBits-1:0] uses_q, uses_d;
  logic [AgeBits-1:0]   age_q, age_d;
  logic                 me;

  assign me = (ctl_i.slot == idx_i);

  // apply the broadcast operation to this entry
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    uses_d  = uses_q;
    age_d   = age_q;
    unique case (ctl_i.op)
      OpHit: begin
        if (me) begin
          age_d = '0;
          if (uses_q != '1) uses_d = uses_q + 1'b1;
        end else if (valid_q && age_q < ctl_i.age) begin
          age_d = age_q + 1'b1;
        end
      end
      OpInsert: begin
        if (me) begin
          valid_d = 1'b1;
          key_d   = ctl_i.key;
          uses_d  = {{(CountBits-1){1'b0}}, 1'b1};
          age_d   = '0;
        end else if (valid_q) begin
          age_d = age_q + 1'b1;
        end
      end
      OpRelease: begin
        if (me && valid_q && uses_q != '0) uses_d = uses_q - 1'b1;
      end
      OpEvict: begin
        if (me) begin
          valid_d = 1'b0;
          uses_d  = '0;
          age_d   = '0;
        end
      end
      OpCompact: begin
        // an evicted age below this one closes the gap
        if (valid_q && age_q > ctl_i.age) age_d = age_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      uses_q  <= '0;
      age_q   <= '0;
    end else begin
      valid_q <= valid_d;
      uses_q  <= uses_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign st_o = '{valid: valid_q, key: key_q, uses: uses_q, age: age_q};
endmodule

### rtl/core/lru_ev_checker.sv
// port checker for the lru evictor
// depends on the top level ports and lru_ev_pkg; bound below
module lru_ev_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o,
  input logic        last_o
);
  import lru_ev_pkg::*;

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(last_o))
    else $error("stalled word changed");

  // no result right after reset is released
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result after reset");

  // an accepted command word blocks the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i != CmdUnused |=> in_stall_o)
    else $error("input not blocked while busy");
endmodule

bind lru_evictor_with_pin_counts lru_ev_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .cmd_i(cmd_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .kind_o(kind_o), .last_o(last_o)
);
